// ===== sv/tmps_pkg.sv =====
// shared types and constants for the triangle minimum path sum block
`default_nettype none

package tmps_pkg;

  // field widths
  localparam int ValueW = 16;
  localparam int TotalW = 26;

  // width used for saturating the row minimum, wider than any internal sum
  localparam int WideW = 34;

  // saturation limits of the result, in the wide format
  localparam logic signed [WideW-1:0] OutMaxWide = 34'sd33554431;
  localparam logic signed [WideW-1:0] OutMinWide = -34'sd33554432;

  // saturated result codes
  localparam logic [TotalW-1:0] TotalMax = {1'b0, {(TotalW-1){1'b1}}};
  localparam logic [TotalW-1:0] TotalMin = {1'b1, {(TotalW-1){1'b0}}};

  // position of one request within the triangle, worked out from the counters
  typedef struct packed {
    logic skip;       // row limit reached, request ignored
    logic row_zero;   // apex entry
    logic first_col;  // first entry of its row
    logic row_end;    // closes its row
    logic above;      // a sum exists directly above this entry
    logic err;        // shape error if this request is the final one
  } tmps_pos_t;

endpackage

`default_nettype wire

// ===== sv/tmps_seq.sv =====
// row and column counters that place each request within the triangle
`default_nettype none

module tmps_seq #(
  parameter int MAX_ROWS = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  logic                          last_i,
  output logic [$clog2(MAX_ROWS)-1:0]   rd_addr_o,
  output tmps_pkg::tmps_pos_t           pos_o
);
  import tmps_pkg::*;

  localparam int AW = $clog2(MAX_ROWS);
  localparam int RW = $clog2(MAX_ROWS + 1);

  logic [RW-1:0] row_q, row_d;
  logic [AW-1:0] col_q, col_d;
  logic          ovf_q, ovf_d;
  logic          skip;
  logic          row_end;

  // classify the current position
  always_comb begin
    skip    = row_q >= RW'(MAX_ROWS);
    row_end = !skip && (RW'(col_q) == row_q);
    pos_o.skip      = skip;
    pos_o.row_zero  = row_q == '0;
    pos_o.first_col = col_q == '0;
    pos_o.row_end   = row_end;
    pos_o.above     = RW'(col_q) < row_q;
    pos_o.err       = ovf_q || skip || !row_end;
  end

  assign rd_addr_o = col_q;

  // counter advance
  always_comb begin
    row_d = row_q;
    col_d = col_q;
    ovf_d = ovf_q;
    if (accept_i) begin
      if (last_i) begin
        row_d = '0;
        col_d = '0;
        ovf_d = 1'b0;
      end else if (skip) begin
        ovf_d = 1'b1;
      end else if (row_end) begin
        row_d = row_q + RW'(1);
        col_d = '0;
      end else begin
        col_d = col_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
      ovf_q <= 1'b0;
    end else begin
      row_q <= row_d;
      col_q <= col_d;
      ovf_q <= ovf_d;
    end
  end

endmodule

`default_nettype wire

// ===== sv/tmps_rowbuf.sv =====
// row buffer of running path sums, one write and one registered read a cycle
`default_nettype none

module tmps_rowbuf #(
  parameter int MAX_ROWS = 1024
) (
  input  logic                                                 clk_i,
  input  logic                                                 rd_en_i,
  input  logic [$clog2(MAX_ROWS)-1:0]                          rd_addr_i,
  output logic signed [tmps_pkg::ValueW+$clog2(MAX_ROWS):0]    rd_data_o,
  input  logic                                                 wr_en_i,
  input  logic [$clog2(MAX_ROWS)-1:0]                          wr_addr_i,
  input  logic signed [tmps_pkg::ValueW+$clog2(MAX_ROWS):0]    wr_data_i
);
  import tmps_pkg::*;

  localparam int SW = ValueW + $clog2(MAX_ROWS) + 1;

  logic signed [SW-1:0] mem_q [MAX_ROWS];
  logic signed [SW-1:0] rd_data_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

// ===== sv/tmps_accum.sv =====
// working stage: path sum update, row minimum tracking and result forming
`default_nettype none

module tmps_accum #(
  parameter int MAX_ROWS = 1024
) (
  input  logic                                               clk_i,
  input  logic                                               rst_ni,
  input  logic                                               en_i,
  input  logic                                               accept_i,
  input  logic signed [tmps_pkg::ValueW-1:0]                 value_i,
  input  logic                                               last_i,
  input  logic [$clog2(MAX_ROWS)-1:0]                        addr_i,
  input  tmps_pkg::tmps_pos_t                                pos_i,
  input  logic signed [tmps_pkg::ValueW+$clog2(MAX_ROWS):0]  rd_data_i,
  output logic                                               wr_en_o,
  output logic [$clog2(MAX_ROWS)-1:0]                        wr_addr_o,
  output logic signed [tmps_pkg::ValueW+$clog2(MAX_ROWS):0]  wr_data_o,
  output logic                                               hold_last_o,
  output logic                                               res_valid_o,
  output logic signed [tmps_pkg::TotalW-1:0]                 res_total_o,
  output logic                                               res_err_o
);
  import tmps_pkg::*;

  localparam int AW = $clog2(MAX_ROWS);
  localparam int SW = ValueW + AW + 1;

  // stage registers
  logic                 s2_v_q;
  logic [ValueW-1:0]    s2_value_q;
  logic                 s2_last_q;
  logic [AW-1:0]        s2_addr_q;
  tmps_pos_t            s2_pos_q;
  logic                 s2_byp_q;
  logic signed [SW-1:0] s2_byp_data_q;

  // running state
  logic signed [SW-1:0] upper_q, upper_d;
  logic signed [SW-1:0] rmin_q, rmin_d;

  logic                  leave;
  logic signed [SW-1:0]  v_ext;
  logic signed [SW-1:0]  old;
  logic signed [SW-1:0]  pick;
  logic signed [SW-1:0]  sum;
  logic signed [SW-1:0]  rmin_new;
  logic signed [WideW-1:0] rmin_wide;

  assign leave = s2_v_q && en_i;

  // path sum for the entry in the stage
  always_comb begin
    v_ext = {{(SW-ValueW){s2_value_q[ValueW-1]}}, s2_value_q};
    if (!s2_pos_q.above) begin
      old = '0;
    end else if (s2_byp_q) begin
      old = s2_byp_data_q;
    end else begin
      old = rd_data_i;
    end
    pick = (old < upper_q) ? old : upper_q;
    if (s2_pos_q.row_zero) begin
      sum = v_ext;
    end else if (s2_pos_q.first_col) begin
      sum = v_ext + old;
    end else if (s2_pos_q.row_end) begin
      sum = v_ext + upper_q;
    end else begin
      sum = v_ext + pick;
    end
  end

  // row minimum and upper-left sum
  always_comb begin
    rmin_new = rmin_q;
    upper_d  = upper_q;
    if (!s2_pos_q.skip) begin
      if (s2_pos_q.first_col || (sum < rmin_q)) begin
        rmin_new = sum;
      end
      upper_d = s2_pos_q.row_end ? '0 : old;
    end
    rmin_d = rmin_new;
    if (s2_last_q) begin
      upper_d = '0;
      rmin_d  = '0;
    end
  end

  // saturated result
  always_comb begin
    rmin_wide = {{(WideW-SW){rmin_new[SW-1]}}, rmin_new};
    if (s2_pos_q.err) begin
      res_total_o = '0;
    end else if (rmin_wide > OutMaxWide) begin
      res_total_o = TotalMax;
    end else if (rmin_wide < OutMinWide) begin
      res_total_o = TotalMin;
    end else begin
      res_total_o = rmin_wide[TotalW-1:0];
    end
  end

  assign res_err_o   = s2_pos_q.err;
  assign res_valid_o = leave && s2_last_q;
  assign hold_last_o = s2_v_q && s2_last_q;
  assign wr_en_o     = leave && !s2_pos_q.skip;
  assign wr_addr_o   = s2_addr_q;
  assign wr_data_o   = sum;

  // stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q  <= 1'b0;
      upper_q <= '0;
      rmin_q  <= '0;
    end else begin
      if (en_i) begin
        s2_v_q <= accept_i;
      end
      if (leave) begin
        upper_q <= upper_d;
        rmin_q  <= rmin_d;
      end
    end
  end

  // stage payload, with forwarding of a sum written in the same cycle as its read
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      s2_value_q    <= value_i;
      s2_last_q     <= last_i;
      s2_addr_q     <= addr_i;
      s2_pos_q      <= pos_i;
      s2_byp_q      <= s2_v_q && !s2_pos_q.skip && (addr_i == s2_addr_q);
      s2_byp_data_q <= sum;
    end
  end

endmodule

`default_nettype wire

// ===== sv/triangle_min_path_sum_core.sv =====
// Triangle minimum path sum core.
// Input channel (in_valid_i / in_ready_o) takes one triangle entry per request in
// row-major order; row r holds r+1 entries and last_i marks the final entry.
// Output channel (out_valid_o / out_ready_i) gives one result per triangle:
// min_total_o, the smallest top-to-bottom path total saturated to 26 bits,
// and shape_error_o, set when last_i closed no row or the row limit was passed
// (min_total_o is then zero).
// Throughput: one entry per cycle unless in_ready_o is held low. The row buffer
// has one write and one registered read port; each entry reads its column as it
// is accepted and writes its new sum from the working stage register, with
// forwarding when both hit one entry. The result of the final entry is formed
// in the working stage and registered in the output register, which drives
// out_valid_o. Reset clears counters and control at once; the row buffer needs
// no clearing, so entries are taken as soon as reset is released.
// While a result waits for out_ready_i, entries keep flowing; only a second
// final entry reaching the working stage holds in_ready_o low until the
// waiting result is taken.
`default_nettype none

module triangle_min_path_sum_core #(
  parameter int MAX_ROWS = 1024
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic signed [tmps_pkg::ValueW-1:0] value_i,
  input  logic                               last_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [tmps_pkg::TotalW-1:0] min_total_o,
  output logic                               shape_error_o
);
  import tmps_pkg::*;

  localparam int AW = $clog2(MAX_ROWS);
  localparam int SW = ValueW + AW + 1;

  logic                  en;
  logic                  accept;
  logic [AW-1:0]         rd_addr;
  tmps_pos_t             pos;
  logic signed [SW-1:0]  rd_data;
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic signed [SW-1:0]  wr_data;
  logic                  hold_last;
  logic                  res_valid;
  logic signed [TotalW-1:0] res_total;
  logic                  res_err;

  logic                     out_v_q, out_v_d;
  logic signed [TotalW-1:0] total_q;
  logic                     err_q;

  // pipeline advance: only a result with nowhere to go holds it
  assign en         = !(hold_last && out_v_q && !out_ready_i);
  assign in_ready_o = en;
  assign accept     = in_valid_i && en;

  tmps_seq #(.MAX_ROWS(MAX_ROWS)) u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .last_i    (last_i),
    .rd_addr_o (rd_addr),
    .pos_o     (pos)
  );

  tmps_rowbuf #(.MAX_ROWS(MAX_ROWS)) u_rowbuf (
    .clk_i     (clk_i),
    .rd_en_i   (accept),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  tmps_accum #(.MAX_ROWS(MAX_ROWS)) u_accum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .accept_i    (accept),
    .value_i     (value_i),
    .last_i      (last_i),
    .addr_i      (rd_addr),
    .pos_i       (pos),
    .rd_data_i   (rd_data),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data),
    .hold_last_o (hold_last),
    .res_valid_o (res_valid),
    .res_total_o (res_total),
    .res_err_o   (res_err)
  );

  // output register
  always_comb begin
    out_v_d = out_v_q;
    if (res_valid) begin
      out_v_d = 1'b1;
    end else if (out_ready_i) begin
      out_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else begin
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      total_q <= res_total;
      err_q   <= res_err;
    end
  end

  assign out_valid_o   = out_v_q;
  assign min_total_o   = total_q;
  assign shape_error_o = err_q;

endmodule

`default_nettype wire

// ===== sv/tmps_checker.sv =====
// port-level checks for the triangle minimum path sum core and their binding
`default_nettype none

module tmps_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_ready_o,
  input logic signed [tmps_pkg::ValueW-1:0] value_i,
  input logic                               last_i,
  input logic                               out_valid_o,
  input logic                               out_ready_i,
  input logic signed [tmps_pkg::TotalW-1:0] min_total_o,
  input logic                               shape_error_o
);

  // no result is offered right after reset has been sampled active
  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |=> !out_valid_o)
    else $error("result offered during reset");

  // a malformed triangle always reports a zero total
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && shape_error_o |-> min_total_o == '0)
    else $error("shape error with non-zero total");

  // requests are refused only behind a stalled result
  a_ready_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("request refused without a stalled result");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(min_total_o) && $stable(shape_error_o))
    else $error("stalled result changed");

endmodule

bind triangle_min_path_sum_core tmps_checker u_tmps_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .value_i       (value_i),
  .last_i        (last_i),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .min_total_o   (min_total_o),
  .shape_error_o (shape_error_o)
);

`default_nettype wire
